// ===== rtl/fir_q15_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_q15_pkg: shared types and constants of the Q15 FIR filter
// Widths, tap count, command codes, controller states and control bundle.
// ----------------------------------------------------------------------------
package fir_q15_pkg;

    localparam int TAPS     = 64;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 6;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    // Exact sum width: product plus log2(TAPS) growth bits.
    localparam int OUT_W    = PROD_W + $clog2(TAPS);

    // Packed beat widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((SAMPLE_W + IDX_W + COEF_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Field positions inside the slave tdata.
    localparam int SAMPLE_LSB = 0;
    localparam int IDX_LSB    = SAMPLE_LSB + SAMPLE_W;
    localparam int COEF_LSB   = IDX_LSB + IDX_W;

    // Cycles from sample accept until the last cell's sum is settled.
    localparam int LAT   = TAPS + 1;
    localparam int CNT_W = $clog2(LAT + 1);

    // Command codes carried in tuser.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_HOLD
    } t_state;

    // Controller to datapath strobes.
    typedef struct packed {
        logic shift;    // advance the delay line by one sample
        logic coef_we;  // write one coefficient
        logic load;     // capture the finished sum into the output register
    } t_ctl;

endpackage

// ===== rtl/fir_filter_q15_top.sv =====
// ----------------------------------------------------------------------------
// fir_filter_q15_top: 64-tap direct-form FIR filter, Q15 samples and coefs
// A row of tap cells holds the delay line and coefficients; partial sums
// ripple down the row and the last cell's sum is the exact filter output.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis): each beat is a command. tuser = 0 pushes a new
//   sample into the delay line and yields one result; tuser = 1 writes one
//   coefficient (coef_index, coef_value) and yields nothing. The 6-bit index
//   reaches every tap, 0 to 63.
//   Master channel (m_axis): one beat per sample, the exact signed 38-bit
//   sum of coefficient times sample over all taps (Q30 scaling).
//   Result path: an accepted sample is shifted into the cells, each cell
//   registers its product and then its sum, and the sum settles one cell per
//   cycle down the 64-cell chain before it is loaded into the output register.
//   Pacing: s_axis is ready only while idle, so a new beat waits until the last
//   sample's sum is loaded; back-to-back coefficient writes go at full rate.
//   Stall: the output register holds a finished result while m_axis is
//   stalled; a new beat is still accepted meanwhile. If the next sum is
//   done before the held one is taken, the chain waits and s_axis stays
//   not ready until the output register frees up.
//   Reset: synchronous, active low; clears delay line, coefficients, the
//   controller and the output valid flag.
// ----------------------------------------------------------------------------
module fir_filter_q15_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: [15:0] sample, [21:16] coef_index, [37:22] coef_value, [39:38] zero
    input  logic [fir_q15_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: [0] func (0 = sample, 1 = coefficient write)
    input  logic [0:0]                            i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata: [37:0] filtered, [39:38] zero
    output logic [fir_q15_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);

    fir_q15_pkg::t_ctl                          ctl;
    logic signed [fir_q15_pkg::SAMPLE_W-1:0]    new_sample;
    logic [fir_q15_pkg::IDX_W-1:0]              coef_idx;
    logic signed [fir_q15_pkg::COEF_W-1:0]      coef_val;

    // Sample and sum links between neighboring cells.
    logic signed [fir_q15_pkg::SAMPLE_W-1:0]    smp_link [fir_q15_pkg::TAPS+1];
    logic signed [fir_q15_pkg::OUT_W-1:0]       sum_link [fir_q15_pkg::TAPS+1];

    logic signed [fir_q15_pkg::OUT_W-1:0]       r_out;

    assign new_sample = i_s_axis_tdata[fir_q15_pkg::SAMPLE_LSB +: fir_q15_pkg::SAMPLE_W];
    assign coef_idx   = i_s_axis_tdata[fir_q15_pkg::IDX_LSB +: fir_q15_pkg::IDX_W];
    assign coef_val   = i_s_axis_tdata[fir_q15_pkg::COEF_LSB +: fir_q15_pkg::COEF_W];

    fir_q15_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_func      (i_s_axis_tuser[0]),
        .o_ready     (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_ctl       (ctl)
    );

    // Newest sample enters at the top cell; the sum starts at zero at cell 0.
    assign smp_link[fir_q15_pkg::TAPS] = new_sample;
    assign sum_link[0]                 = '0;

    for (genvar k = 0; k < fir_q15_pkg::TAPS; k++) begin : g_tap
        logic coef_we;

        assign coef_we = ctl.coef_we && (int'(coef_idx) == k);

        fir_q15_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (ctl.shift),
            .i_sample  (smp_link[k+1]),
            .o_sample  (smp_link[k]),
            .i_coef_we (coef_we),
            .i_coef    (coef_val),
            .i_sum     (sum_link[k]),
            .o_sum     (sum_link[k+1])
        );
    end

    // Output register: capture the settled sum from the last cell.
    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_out <= sum_link[fir_q15_pkg::TAPS];
        end
    end

    assign o_m_axis_tdata = {{(fir_q15_pkg::M_TDATA_W - fir_q15_pkg::OUT_W){1'b0}}, r_out};

endmodule

// ===== rtl/fir_q15_cell.sv =====
// ----------------------------------------------------------------------------
// fir_q15_cell: one tap of the FIR chain
// Holds one delayed sample and one coefficient, forms their product and adds
// it to the partial sum handed over by the previous cell.
// ----------------------------------------------------------------------------
module fir_q15_cell (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_shift,
    input  logic signed [fir_q15_pkg::SAMPLE_W-1:0]  i_sample,
    output logic signed [fir_q15_pkg::SAMPLE_W-1:0]  o_sample,
    input  logic                                     i_coef_we,
    input  logic signed [fir_q15_pkg::COEF_W-1:0]    i_coef,
    input  logic signed [fir_q15_pkg::OUT_W-1:0]     i_sum,
    output logic signed [fir_q15_pkg::OUT_W-1:0]     o_sum
);

    logic signed [fir_q15_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [fir_q15_pkg::COEF_W-1:0]   r_coef;
    logic signed [fir_q15_pkg::PROD_W-1:0]   r_prod;
    logic signed [fir_q15_pkg::OUT_W-1:0]    r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
            r_coef   <= '0;
        end else begin
            if (i_shift) begin
                r_sample <= i_sample;
            end
            if (i_coef_we) begin
                r_coef <= i_coef;
            end
        end
    end

    // Product and partial sum recompute every cycle; the sum wave settles
    // one cell per cycle down the chain.
    always_ff @(posedge i_clk) begin
        r_prod <= r_sample * r_coef;
        r_sum  <= i_sum + fir_q15_pkg::OUT_W'(r_prod);
    end

    assign o_sample = r_sample;
    assign o_sum    = r_sum;

endmodule

// ===== rtl/fir_q15_ctrl.sv =====
// ----------------------------------------------------------------------------
// fir_q15_ctrl: handshake and sequencing for the FIR chain
// Accepts beats, times the sum settling through the cells and manages the
// output register's valid flag.
// ----------------------------------------------------------------------------
module fir_q15_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_func,
    output logic               o_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output fir_q15_pkg::t_ctl  o_ctl
);

    fir_q15_pkg::t_state             r_state;
    fir_q15_pkg::t_state             n_state;
    logic [fir_q15_pkg::CNT_W-1:0]   r_cnt;
    logic                            r_out_valid;
    logic                            accept;
    logic                            slot_free;
    logic                            sum_ready;

    assign o_ready   = (r_state == fir_q15_pkg::S_IDLE);
    assign accept    = i_valid && o_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign sum_ready = (r_cnt == fir_q15_pkg::CNT_W'(fir_q15_pkg::LAT));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fir_q15_pkg::S_IDLE: begin
                if (accept && (i_func == fir_q15_pkg::FUNC_SAMPLE)) begin
                    n_state = fir_q15_pkg::S_CALC;
                end
            end
            fir_q15_pkg::S_CALC: begin
                if (sum_ready) begin
                    n_state = slot_free ? fir_q15_pkg::S_IDLE : fir_q15_pkg::S_HOLD;
                end
            end
            fir_q15_pkg::S_HOLD: begin
                if (slot_free) begin
                    n_state = fir_q15_pkg::S_IDLE;
                end
            end
            default: n_state = fir_q15_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.shift   = accept && (i_func == fir_q15_pkg::FUNC_SAMPLE);
        o_ctl.coef_we = accept && (i_func == fir_q15_pkg::FUNC_COEF);
        o_ctl.load    = slot_free &&
                        (((r_state == fir_q15_pkg::S_CALC) && sum_ready) ||
                         (r_state == fir_q15_pkg::S_HOLD));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fir_q15_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fir_q15_pkg::S_CALC && !sum_ready) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (r_state != fir_q15_pkg::S_CALC) begin
                r_cnt <= '0;
            end
            if (o_ctl.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 64-tap Q15 FIR filter
// Streams sample and coefficient-write beats through the slave channel,
// predicts every filter sum in a behavioral model of the delay line and
// coefficient bank, and checks each master beat in order. Four handshake
// phases cover free flow, sender gaps, receiver stalls and both at once,
// plus one long receiver hold-off that backs the filter up to its input.
// ----------------------------------------------------------------------------
module tb;
    import fir_q15_pkg::*;

    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     LONG_HOLD      = 400;
    localparam int     PHASE_BEATS    = 300;
    localparam longint SUM_MAX        = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint SUM_MIN        = -SUM_MAX - 1;

    typedef enum int {
        GAP_NONE,
        GAP_SRC,
        GAP_SNK,
        GAP_BOTH
    } gap_mode_t;

    typedef struct {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           idx;
        logic signed [COEF_W-1:0]   cval;
    } fir_beat_t;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic [0:0]           i_s_axis_tuser  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    // Behavioral copy of the filter state
    logic signed [SAMPLE_W-1:0] delay_hist [TAPS] = '{default: '0};
    logic signed [COEF_W-1:0]   coef_bank  [TAPS] = '{default: '0};

    fir_beat_t                beats_pending [$];
    logic signed [OUT_W-1:0]  filtered_due  [$];

    gap_mode_t gap_mode       = GAP_NONE;
    logic      s_taken        = 1'b0;
    int        beats_queued   = 0;
    int        beats_accepted = 0;
    int        samples_queued = 0;
    int        coefs_queued   = 0;
    int        results_seen   = 0;
    int        mismatches     = 0;
    int        quiet_cycles   = 0;
    int        hold_reqs      = 0;
    int        hold_seen      = 0;
    int        hold_left      = 0;

    fir_filter_q15_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Advance the delay line, insert the newest sample at the top and
    // return the exact sum of coefficient times delayed sample.
    function automatic logic signed [OUT_W-1:0] shift_in_sample(
        logic signed [SAMPLE_W-1:0] s);
        longint acc;
        acc = 0;
        for (int k = 0; k < TAPS - 1; k++) delay_hist[k] = delay_hist[k + 1];
        delay_hist[TAPS - 1] = s;
        for (int k = 0; k < TAPS; k++)
            acc += longint'(coef_bank[k]) * longint'(delay_hist[k]);
        // Never reached: OUT_W leaves room for the largest possible sum
        if (acc > SUM_MAX) acc = SUM_MAX;
        if (acc < SUM_MIN) acc = SUM_MIN;
        return acc[OUT_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    // Mostly random Q15 values, with the extremes and the values around
    // zero showing up often.
    function automatic logic signed [15:0] pick_q15();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            2:       return 16'sd0;
            3:       return 16'sd1;
            4:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Unused fields carry random junk; the filter must ignore them.
    task automatic add_sample(logic signed [SAMPLE_W-1:0] s);
        fir_beat_t b;
        b.func   = FUNC_SAMPLE;
        b.sample = s;
        b.idx    = IDX_W'($urandom);
        b.cval   = COEF_W'($urandom);
        beats_pending.insert(beats_pending.size(), b);
        beats_queued++;
        samples_queued++;
    endtask

    task automatic add_coef(logic [IDX_W-1:0] i, logic signed [COEF_W-1:0] v);
        fir_beat_t b;
        b.func   = FUNC_COEF;
        b.sample = SAMPLE_W'($urandom);
        b.idx    = i;
        b.cval   = v;
        beats_pending.insert(beats_pending.size(), b);
        beats_queued++;
        coefs_queued++;
    endtask

    task automatic queue_directed();
        // Weight the newest and oldest taps at the extremes
        add_coef(6'd63, 16'sh7FFF);
        add_coef(6'd62, -16'sh8000);
        add_coef(6'd0, -16'sh8000);
        add_coef(6'd1, 16'sd1);
        add_sample(16'sh7FFF);
        add_sample(-16'sh8000);
        add_sample(16'sd0);
        add_sample(-16'sd1);
        add_sample(16'sd1);
        // Coefficient write between samples leaves the delay line alone
        add_coef(6'd63, 16'sd0);
        add_sample(16'sh7FFF);
        add_coef(6'd32, -16'sd1);
        add_coef(6'd31, 16'sh7FFF);
        add_sample(-16'sh8000);
        add_sample(-16'sh8000);
        add_sample(16'sh7FFF);
        add_coef(6'd63, -16'sh8000);
        add_sample(-16'sh8000);
        add_sample(16'sh5555);
        add_sample(-16'sh2AAB);
        add_coef(6'd0, 16'sd0);
        add_sample(16'sd0);
        add_sample(16'sh7FFF);
    endtask

    // Fill every tap; mode picks all-minimum, all-maximum or random values.
    task automatic load_coef_set(int mode);
        for (int i = 0; i < TAPS; i++) begin
            case (mode)
                1:       add_coef(i[IDX_W-1:0], -16'sh8000);
                2:       add_coef(i[IDX_W-1:0], 16'sh7FFF);
                default: add_coef(i[IDX_W-1:0], pick_q15());
            endcase
        end
    endtask

    task automatic queue_random_group();
        int n;
        case ($urandom_range(0, 19))
            0: load_coef_set(0);
            1, 2, 3: begin
                n = $urandom_range(1, 4);
                repeat (n) add_coef(IDX_W'($urandom), pick_q15());
            end
            default: begin
                n = $urandom_range(1, 12);
                repeat (n) add_sample(pick_q15());
            end
        endcase
    endtask

    task automatic queue_phase(int ph);
        int start;
        start = beats_queued;
        load_coef_set(ph);
        // Drive the sum to its largest magnitudes with a full line of extremes
        if (ph == 1 || ph == 2) repeat (TAPS + 4) add_sample(-16'sh8000);
        while (beats_queued - start < PHASE_BEATS) queue_random_group();
    endtask

    // ------------------------------------------------------------------------
    // Sender: present a new beat once the current one is taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : beat_driver
        fir_beat_t            b;
        logic [S_TDATA_W-1:0] d;
        int                   gap_pct;
        gap_pct = (gap_mode == GAP_SRC) ? 66 : (gap_mode == GAP_BOTH) ? 36 : 0;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || s_taken) begin
            if (beats_pending.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                b = beats_pending.pop_front();
                d = '0;
                d[SAMPLE_LSB +: SAMPLE_W] = b.sample;
                d[IDX_LSB +: IDX_W]       = b.idx;
                d[COEF_LSB +: COEF_W]     = b.cval;
                i_s_axis_tdata  <= d;
                i_s_axis_tuser  <= b.func;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_sink
        int stall_pct;
        stall_pct = (gap_mode == GAP_SNK) ? 66 : (gap_mode == GAP_BOTH) ? 36 : 0;
        if (hold_seen != hold_reqs) begin
            hold_seen       <= hold_reqs;
            hold_left       <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each slave beat, check each master beat, watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_monitor
        logic                       s_fire;
        logic                       m_fire;
        logic signed [OUT_W-1:0]    want;
        logic signed [OUT_W-1:0]    got;
        s_fire  = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        m_fire  = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        s_taken <= s_fire;
        if (s_fire) begin
            beats_accepted++;
            if (i_s_axis_tuser[0] == FUNC_COEF) begin
                if (i_s_axis_tdata[IDX_LSB +: IDX_W] < TAPS)
                    coef_bank[i_s_axis_tdata[IDX_LSB +: IDX_W]] =
                        i_s_axis_tdata[COEF_LSB +: COEF_W];
            end else begin
                filtered_due.insert(filtered_due.size(),
                    shift_in_sample(i_s_axis_tdata[SAMPLE_LSB +: SAMPLE_W]));
            end
        end
        if (m_fire) begin
            results_seen++;
            got = o_m_axis_tdata[OUT_W-1:0];
            if (filtered_due.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result beat: expected none, actual %0d",
                         $time, got);
            end else begin
                want = filtered_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t filtered mismatch: expected %0d, actual %0d",
                             $time, want, got);
                end
            end
        end
        // Count cycles with no beat on either side
        if (!i_rst_n || s_fire || m_fire) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: reset, then run the four handshake phases
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = GAP_NONE; ph <= GAP_BOTH; ph++) begin
            @(posedge i_clk);
            gap_mode <= gap_mode_t'(ph);
            if (ph == GAP_NONE) begin
                queue_directed();
                // Hold off the receiver while the sender keeps offering
                hold_reqs++;
            end
            queue_phase(ph);
            while (beats_accepted != beats_queued || filtered_due.size() != 0)
                @(negedge i_clk);
        end
        // Let any stray result show up before the verdict
        repeat (2 * LAT) @(negedge i_clk);
        if (filtered_due.size() != 0) begin
            mismatches++;
            $display("%0t %0d filtered results never arrived", $time,
                     filtered_due.size());
        end
        $display("Sent %0d beats (%0d samples, %0d coefficient writes) in four",
                 beats_queued, samples_queued, coefs_queued);
        $display("handshake phases with one long stall; %0d results checked",
                 results_seen);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
